[sv/spqs_pkg.sv]
// shared types, codes and tables of the shaped priority queue scheduler
package spqs_pkg;

  localparam int unsigned NUM_CLS = 5;

  // command codes of an input word
  localparam logic [2:0] CMD_PUSH      = 3'd0;
  localparam logic [2:0] CMD_POP_ANY   = 3'd1;
  localparam logic [2:0] CMD_POP_CLASS = 3'd2;
  localparam logic [2:0] CMD_TICK      = 3'd3;
  localparam logic [2:0] CMD_DROP      = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_RATE0 = 3'd0;
  localparam logic [2:0] REG_RATE4 = 3'd4;
  localparam logic [2:0] REG_BURST = 3'd5;
  localparam logic [2:0] REG_LIMIT = 3'd6;

  // datapath operations issued by the controller
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_PUSH   = 3'd1;
  localparam logic [2:0] OP_READ   = 3'd2;
  localparam logic [2:0] OP_SERVE  = 3'd3;
  localparam logic [2:0] OP_CAP    = 3'd4;
  localparam logic [2:0] OP_REFILL = 3'd5;
  localparam logic [2:0] OP_SHED   = 3'd6;

  localparam logic [2:0] LAST_SERVE = 3'd4;
  localparam logic [2:0] LAST_SHED  = 3'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  class_select;
    logic [15:0] packet_length;
    logic [15:0] packet_tag;
    logic        force_push;
    logic [6:0]  drop_threshold_pct;
  } item_t;

  typedef struct packed {
    logic        success;
    logic [2:0]  served_class;
    logic [15:0] served_length;
    logic [15:0] served_tag;
    logic [7:0]  dropped_count;
    logic        congestion_warn;
    logic [6:0]  queue_level;
  } result_t;

  typedef struct packed {
    logic       load;
    logic       finish;
    logic [2:0] op;
    logic [2:0] cls;
  } ctl_t;

  typedef struct packed {
    logic       occ_nz;
    logic       serve_ok;
    logic [2:0] item_cls;
  } stat_t;

  // pop-any visiting order
  function automatic logic [2:0] serve_class(input logic [2:0] idx);
    logic [2:0] c;
    unique case (idx)
      3'd0: c = 3'd0;
      3'd1: c = 3'd4;
      3'd2: c = 3'd2;
      3'd3: c = 3'd1;
      default: c = 3'd3;
    endcase
    return c;
  endfunction

  // drop-congested visiting order
  function automatic logic [2:0] shed_class(input logic [2:0] idx);
    logic [2:0] c;
    unique case (idx)
      3'd0: c = 3'd3;
      3'd1: c = 3'd4;
      3'd2: c = 3'd2;
      default: c = 3'd1;
    endcase
    return c;
  endfunction

endpackage

[sv/spqs_ctrl.sv]
// controller state machine of the scheduler
module spqs_ctrl import spqs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [2:0] command_i,
  input  logic [2:0] class_i,
  input  stat_t      stat_i,
  output ctl_t       ctl_o,
  output logic       busy_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_PUSH     = 3'd1;
  localparam logic [2:0] S_POP_RD   = 3'd2;
  localparam logic [2:0] S_POP_CHK  = 3'd3;
  localparam logic [2:0] S_TICK_MUL = 3'd4;
  localparam logic [2:0] S_TICK_UPD = 3'd5;
  localparam logic [2:0] S_SHED     = 3'd6;
  localparam logic [2:0] S_NOP      = 3'd7;

  logic [2:0] state_q, state_d;
  logic [2:0] idx_q, idx_d;
  logic       any_q, any_d;
  logic       cls_ok;

  assign busy_o = (state_q != S_IDLE);
  assign cls_ok = (class_i < 3'(NUM_CLS));

  // sequencing of one word
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    any_d   = any_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          idx_d      = '0;
          any_d      = 1'b0;
          case (command_i)
            CMD_PUSH:      state_d = cls_ok ? S_PUSH : S_NOP;
            CMD_POP_ANY: begin
              state_d = S_POP_RD;
              any_d   = 1'b1;
            end
            CMD_POP_CLASS: state_d = cls_ok ? S_POP_RD : S_NOP;
            CMD_TICK:      state_d = S_TICK_MUL;
            CMD_DROP:      state_d = S_SHED;
            default:       state_d = S_NOP;
          endcase
        end
      end
      S_PUSH: begin
        ctl_o.op     = OP_PUSH;
        ctl_o.cls    = stat_i.item_cls;
        ctl_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      S_POP_RD: begin
        ctl_o.cls = any_q ? serve_class(idx_q) : stat_i.item_cls;
        if (stat_i.occ_nz) begin
          ctl_o.op = OP_READ;
          state_d  = S_POP_CHK;
        end else if (any_q && idx_q != LAST_SERVE) begin
          idx_d = idx_q + 3'd1;
        end else begin
          ctl_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_POP_CHK: begin
        ctl_o.cls = any_q ? serve_class(idx_q) : stat_i.item_cls;
        ctl_o.op  = OP_SERVE;
        if (stat_i.serve_ok || !any_q || idx_q == LAST_SERVE) begin
          ctl_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          idx_d   = idx_q + 3'd1;
          state_d = S_POP_RD;
        end
      end
      S_TICK_MUL: begin
        ctl_o.cls = idx_q;
        ctl_o.op  = OP_CAP;
        state_d   = S_TICK_UPD;
      end
      S_TICK_UPD: begin
        ctl_o.cls = idx_q;
        ctl_o.op  = OP_REFILL;
        if (idx_q == 3'(NUM_CLS - 1)) begin
          ctl_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          idx_d   = idx_q + 3'd1;
          state_d = S_TICK_MUL;
        end
      end
      S_SHED: begin
        ctl_o.cls = shed_class(idx_q);
        ctl_o.op  = OP_SHED;
        if (idx_q == LAST_SHED) begin
          ctl_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      default: begin
        ctl_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      any_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      any_q   <= any_d;
    end
  end

endmodule

[sv/spqs_dp.sv]
// datapath: queues, buckets, entry memory and result registers
module spqs_dp import spqs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  item_t       item_i,
  input  ctl_t        ctl_i,
  output stat_t       stat_o,
  output logic        valid_o,
  output result_t     result_o
);

  localparam int unsigned OCC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned HEAD_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned ADDR_W = $clog2(NUM_CLS * QUEUE_DEPTH);
  localparam int unsigned CW     = (OCC_W > 7) ? OCC_W : 7;
  localparam int unsigned DROP_W = OCC_W + 2;

  // configuration
  logic [23:0] rate_q [NUM_CLS];
  logic [15:0] burst_q;
  logic [6:0]  limit_q;

  // per-class state
  logic [HEAD_W-1:0] head_q [NUM_CLS];
  logic [OCC_W-1:0]  occ_q  [NUM_CLS];
  logic [39:0]       tok_q  [NUM_CLS];

  // entry memory, {length, tag}
  logic [31:0] mem_q [NUM_CLS * QUEUE_DEPTH];
  logic [31:0] rdata_q;
  logic [39:0] cap_q;

  item_t             item_q;
  logic              valid_q;
  logic              success_q, warn_q;
  logic [2:0]        srv_cls_q;
  logic [15:0]       srv_len_q, srv_tag_q;
  logic [6:0]        level_q;
  logic [DROP_W-1:0] drop_q;

  logic [HEAD_W-1:0] head_s;
  logic [OCC_W-1:0]  occ_s;
  logic [39:0]       tok_s;
  logic [23:0]       rate_s;
  logic [CW-1:0]     lim_raw, lim_cw, occ_cw;
  logic [OCC_W-1:0]  lim;

  // selected class
  assign head_s = head_q[ctl_i.cls];
  assign occ_s  = occ_q[ctl_i.cls];
  assign tok_s  = tok_q[ctl_i.cls];
  assign rate_s = rate_q[ctl_i.cls];
  assign occ_cw = CW'(occ_s);

  // effective limit clamped to 1..depth
  assign lim_raw = CW'(limit_q);
  always_comb begin
    if (lim_raw == '0)                    lim_cw = CW'(1);
    else if (lim_raw > CW'(QUEUE_DEPTH)) lim_cw = CW'(QUEUE_DEPTH);
    else                                  lim_cw = lim_raw;
  end
  assign lim = lim_cw[OCC_W-1:0];

  // push: optional forced drop of the oldest entry, then append
  logic              push_full, push_drop, push_ok, push_warn;
  logic [HEAD_W-1:0] push_head;
  logic [OCC_W-1:0]  push_occ;
  logic [HEAD_W:0]   push_sum;
  logic [HEAD_W-1:0] push_slot;
  logic [6:0]        push_level;

  assign push_full = (occ_s >= lim);
  assign push_drop = push_full && item_q.force_push && (occ_s != '0);
  always_comb begin
    push_head = head_s;
    if (push_drop) begin
      push_head = (head_s == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : head_s + HEAD_W'(1);
    end
  end
  assign push_occ  = push_drop ? occ_s - OCC_W'(1) : occ_s;
  assign push_ok   = !push_full || (item_q.force_push && (push_occ < lim));
  assign push_sum  = (HEAD_W+1)'(push_head) + (HEAD_W+1)'(push_occ);
  assign push_slot = (push_sum >= (HEAD_W+1)'(QUEUE_DEPTH))
                   ? HEAD_W'(push_sum - (HEAD_W+1)'(QUEUE_DEPTH)) : HEAD_W'(push_sum);
  assign push_warn = ((OCC_W+3)'(occ_s) * (OCC_W+3)'(5)) >
                     ((OCC_W+3)'(lim) * (OCC_W+3)'(4));
  assign push_level = (occ_cw > CW'(127)) ? 7'd127 : occ_cw[6:0];

  // memory addresses
  logic [ADDR_W-1:0] base, wr_addr, rd_addr;
  assign base    = ADDR_W'(ctl_i.cls) * ADDR_W'(QUEUE_DEPTH);
  assign wr_addr = base + ADDR_W'(push_slot);
  assign rd_addr = base + ADDR_W'(head_s);

  // serve check against the head entry read last cycle
  logic [39:0] need;
  logic        serve_ok;
  assign need     = {21'd0, rdata_q[31:16], 3'd0};
  assign serve_ok = (tok_s >= need);

  logic [HEAD_W-1:0] head_inc;
  assign head_inc = (head_s == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : head_s + HEAD_W'(1);

  // tick refill, clamped to the bucket size
  logic [40:0] refill_sum;
  logic [39:0] refill_val;
  assign refill_sum = {1'b0, tok_s} + 41'(rate_s);
  assign refill_val = (refill_sum < {1'b0, cap_q}) ? refill_sum[39:0] : cap_q;

  // drop-congested halving
  logic              shed_hit;
  logic [OCC_W-1:0]  shed_n;
  logic [HEAD_W:0]   shed_sum;
  logic [HEAD_W-1:0] shed_head;
  assign shed_hit  = ((OCC_W+7)'(occ_s) * (OCC_W+7)'(100)) >
                     ((OCC_W+7)'(item_q.drop_threshold_pct) * (OCC_W+7)'(lim));
  assign shed_n    = occ_s >> 1;
  assign shed_sum  = (HEAD_W+1)'(head_s) + (HEAD_W+1)'(shed_n);
  assign shed_head = (shed_sum >= (HEAD_W+1)'(QUEUE_DEPTH))
                   ? HEAD_W'(shed_sum - (HEAD_W+1)'(QUEUE_DEPTH)) : HEAD_W'(shed_sum);

  assign stat_o.occ_nz   = (occ_s != '0);
  assign stat_o.serve_ok = serve_ok;
  assign stat_o.item_cls = item_q.class_select;

  // item latch
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) item_q <= item_i;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLS; i++) rate_q[i] <= '0;
      burst_q <= 16'd1;
      limit_q <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BURST: burst_q <= cfg_data_i[15:0];
        REG_LIMIT: limit_q <= cfg_data_i[6:0];
        default: begin
          if (cfg_idx_i <= REG_RATE4) rate_q[cfg_idx_i - REG_RATE0] <= cfg_data_i;
        end
      endcase
    end
  end

  // per-class state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CLS; i++) begin
        head_q[i] <= '0;
        occ_q[i]  <= '0;
        tok_q[i]  <= '0;
      end
    end else begin
      case (ctl_i.op)
        OP_PUSH: begin
          head_q[ctl_i.cls] <= push_head;
          occ_q[ctl_i.cls]  <= push_ok ? push_occ + OCC_W'(1) : push_occ;
        end
        OP_SERVE: begin
          if (serve_ok) begin
            tok_q[ctl_i.cls]  <= tok_s - need;
            head_q[ctl_i.cls] <= head_inc;
            occ_q[ctl_i.cls]  <= occ_s - OCC_W'(1);
          end
        end
        OP_REFILL: tok_q[ctl_i.cls] <= refill_val;
        OP_SHED: begin
          if (shed_hit) begin
            head_q[ctl_i.cls] <= shed_head;
            occ_q[ctl_i.cls]  <= occ_s - shed_n;
          end
        end
        default: ;
      endcase
    end
  end

  // entry memory and bucket size product
  always_ff @(posedge clk_i) begin
    if (ctl_i.op == OP_PUSH && push_ok) begin
      mem_q[wr_addr] <= {item_q.packet_length, item_q.packet_tag};
    end
    if (ctl_i.op == OP_READ) rdata_q <= mem_q[rd_addr];
    if (ctl_i.op == OP_CAP)  cap_q <= 40'(rate_s) * 40'(burst_q);
  end

  // result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      success_q <= 1'b0;
      warn_q    <= 1'b0;
      srv_cls_q <= '0;
      srv_len_q <= '0;
      srv_tag_q <= '0;
      level_q   <= '0;
      drop_q    <= '0;
    end else begin
      valid_q <= ctl_i.finish;
      if (ctl_i.load) begin
        success_q <= 1'b0;
        warn_q    <= 1'b0;
        srv_cls_q <= '0;
        srv_len_q <= '0;
        srv_tag_q <= '0;
        level_q   <= '0;
        drop_q    <= '0;
      end else begin
        case (ctl_i.op)
          OP_PUSH: begin
            success_q <= push_ok;
            warn_q    <= push_warn;
            level_q   <= push_level;
            drop_q    <= DROP_W'(push_drop);
          end
          OP_SERVE: begin
            if (serve_ok) begin
              success_q <= 1'b1;
              srv_cls_q <= ctl_i.cls;
              srv_len_q <= rdata_q[31:16];
              srv_tag_q <= rdata_q[15:0];
            end
          end
          OP_SHED: begin
            if (shed_hit) drop_q <= drop_q + DROP_W'(shed_n);
          end
          default: ;
        endcase
      end
    end
  end

  assign valid_o                  = valid_q;
  assign result_o.success         = success_q;
  assign result_o.served_class    = srv_cls_q;
  assign result_o.served_length   = srv_len_q;
  assign result_o.served_tag      = srv_tag_q;
  assign result_o.dropped_count   = (drop_q > DROP_W'(255)) ? 8'd255 : 8'(drop_q);
  assign result_o.congestion_warn = warn_q;
  assign result_o.queue_level     = level_q;

endmodule

[sv/shaped_priority_queue_scheduler_unit.sv]
// top level of the token bucket shaped strict priority scheduler
//
// A command word is taken at a clock edge with start_i high and busy_o low.
// Push, pop-any, pop-class, tick and drop-congested commands act on five
// descriptor queues held in one entry memory and on five token buckets.
// Each word gives exactly one result word, shown on result_o for one cycle
// with valid_o high, the cycle after the controller finishes the command.
// The receiver cannot stall; a new word can be taken in the cycle the
// result is shown.
// Steps per word, set by the controller sequence and the one memory port:
//   push, invalid class or unused command: a finishing step only
//   pop-class: finishes on an empty queue, else head read, then bucket check
//   pop-any: skips empty classes, reads and checks nonempty ones until one is served
//   tick: bucket size product, then clamped refill, per class
//   drop-congested: one class per cycle, class 0 is never shed
// Configuration is written on cfg_we_i with no wait; the user must write it only while idle, the block never checks.
// Reset empties every queue and bucket and loads the register defaults;
// the entry memory needs no clearing since only written entries are read.
module shaped_priority_queue_scheduler_unit import spqs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        start_i,
  input  item_t       item_i,
  output logic        busy_o,
  output logic        valid_o,
  output result_t     result_o
);

  ctl_t  ctl;
  stat_t stat;
  logic  busy;

  assign busy_o = busy;

  // command sequencer
  spqs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (item_i.command),
    .class_i   (item_i.class_select),
    .stat_i    (stat),
    .ctl_o     (ctl),
    .busy_o    (busy)
  );

  // queue and bucket datapath
  spqs_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_i),
    .ctl_i      (ctl),
    .stat_o     (stat),
    .valid_o    (valid_o),
    .result_o   (result_o)
  );

endmodule
